@@ rtl/core/pe_pkg.sv @@
package pe_pkg;

    // Field and register widths.
    localparam int DATA_W     = 32;
    localparam int NREGS      = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int COEF_IDX_W = 3;

    // Defaults for the top level parameters.
    localparam int NUM_COEFFS_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;

    // Datapath widths: limit difference, term product, power product.
    localparam int DIFF_W     = DATA_W + 1;
    localparam int PROD_W     = DIFF_W + DATA_W;
    localparam int POW_PROD_W = 2 * DATA_W;

    // Reciprocal multiplier for the coefficient quotients.
    localparam int RECIP_W  = DATA_W + 1;
    localparam int RPROD_W  = DATA_W + RECIP_W;
    localparam int SHIFT_W  = 6;

    // Width of the saturation input, wide enough for any accumulator.
    localparam int SAT_IN_W = 72;

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = SAT_IN_W'(32'sh7FFF_FFFF);
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = SAT_IN_W'(32'sh8000_0000);

    typedef enum logic {
        MODE_EVAL  = 1'b0,
        MODE_INTEG = 1'b1
    } t_mode;

    // Control that travels with each item through the pipeline.
    typedef struct packed {
        logic  valid;
        t_mode mode;
        logic  ovf;
    } t_ctl;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } t_sat;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic t_sat sat32(input logic signed [SAT_IN_W-1:0] v);
        t_sat r;
        r.val = v[DATA_W-1:0];
        r.ovf = 1'b0;
        if (v > SAT_MAX) begin
            r.val = SAT_MAX[DATA_W-1:0];
            r.ovf = 1'b1;
        end else if (v < SAT_MIN) begin
            r.val = SAT_MIN[DATA_W-1:0];
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // Magic multiplier ceil(2^s / d) for divisor d = idx + 1, exact for
    // any 32-bit magnitude.
    function automatic logic [RECIP_W-1:0] recip_mult(input logic [COEF_IDX_W-1:0] idx);
        logic [RECIP_W-1:0] m;
        unique case (idx)
            3'd0:    m = 33'h1_0000_0000;
            3'd1:    m = 33'h1_0000_0000;
            3'd2:    m = 33'h1_5555_5556;
            3'd3:    m = 33'h1_0000_0000;
            3'd4:    m = 33'h1_9999_999A;
            3'd5:    m = 33'h1_5555_5556;
            3'd6:    m = 33'h1_2492_4925;
            3'd7:    m = 33'h1_0000_0000;
            default: m = 33'h1_0000_0000;
        endcase
        return m;
    endfunction

    // Matching right shift s = 32 + ceil(log2(d)).
    function automatic logic [SHIFT_W-1:0] recip_shift(input logic [COEF_IDX_W-1:0] idx);
        logic [SHIFT_W-1:0] s;
        unique case (idx)
            3'd0:    s = 6'd32;
            3'd1:    s = 6'd33;
            3'd2:    s = 6'd34;
            3'd3:    s = 6'd34;
            3'd4:    s = 6'd35;
            3'd5:    s = 6'd35;
            3'd6:    s = 6'd35;
            3'd7:    s = 6'd35;
            default: s = 6'd35;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/pe_intf.sv @@
// Request channel: one beat is one evaluation or integration request.
interface pe_in_if import pe_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] lower_limit;
    logic signed [DATA_W-1:0] upper_limit;

    modport source (output valid, mode, position, lower_limit, upper_limit, input ready);
    modport sink   (input valid, mode, position, lower_limit, upper_limit, output ready);
endinterface

// Result channel: one beat per request.
interface pe_out_if import pe_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic                     overflow;

    modport source (output valid, result_value, overflow, input ready);
    modport sink   (input valid, result_value, overflow, output ready);
endinterface

// Coefficient write channel.
interface pe_cfg_if import pe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/pe_cdiv.sv @@
module pe_cdiv import pe_pkg::*; #(
    parameter int NUM_COEFFS = NUM_COEFFS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  logic [CFG_IDX_W-1:0]     i_idx,
    input  logic [DATA_W-1:0]        i_data,
    output logic signed [DATA_W-1:0] o_quot [NUM_COEFFS]
);

    logic                     r_a_v;
    logic [COEF_IDX_W-1:0]    r_a_idx;
    logic                     r_a_neg;
    logic [DATA_W-1:0]        r_a_mag;
    logic                     r_b_v;
    logic [COEF_IDX_W-1:0]    r_b_idx;
    logic                     r_b_neg;
    logic [RPROD_W-1:0]       r_b_prod;
    logic [SHIFT_W-1:0]       r_b_shift;
    logic signed [DATA_W-1:0] r_quot [NUM_COEFFS];

    logic [DATA_W-1:0]  mag;
    logic [RPROD_W-1:0] prod;
    logic [RPROD_W-1:0] shifted;
    logic [DATA_W-1:0]  q_mag;
    logic [DATA_W-1:0]  q_val;

    // Stage A: magnitude and sign of the written coefficient.
    assign mag = i_data[DATA_W-1] ? (~i_data + DATA_W'(1)) : i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            r_a_v <= i_wr && (i_idx < CFG_IDX_W'(NUM_COEFFS));
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx <= i_idx[COEF_IDX_W-1:0];
        r_a_neg <= i_data[DATA_W-1];
        r_a_mag <= mag;
    end

    // Stage B: multiply by the reciprocal of the term's divisor.
    assign prod = r_a_mag * recip_mult(r_a_idx);

    always_ff @(posedge i_clk) begin
        r_b_idx   <= r_a_idx;
        r_b_neg   <= r_a_neg;
        r_b_prod  <= prod;
        r_b_shift <= recip_shift(r_a_idx);
    end

    // Stage C: shift down, restore the sign (truncation toward zero).
    assign shifted = r_b_prod >> r_b_shift;
    assign q_mag   = shifted[DATA_W-1:0];
    assign q_val   = r_b_neg ? (~q_mag + DATA_W'(1)) : q_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_COEFFS; j++) begin
                r_quot[j] <= '0;
            end
        end else if (r_b_v) begin
            for (int j = 0; j < NUM_COEFFS; j++) begin
                if (r_b_idx == COEF_IDX_W'(j)) begin
                    r_quot[j] <= q_val;
                end
            end
        end
    end

    assign o_quot = r_quot;

endmodule

@@ rtl/core/pe_lane.sv @@
module pe_lane import pe_pkg::*; #(
    parameter int IDX        = 0,
    parameter int NUM_COEFFS = NUM_COEFFS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ACC_W      = PROD_W + 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_ctl                     i_ctl,
    input  logic signed [DATA_W-1:0] i_base_a,
    input  logic signed [DATA_W-1:0] i_base_b,
    input  logic signed [DATA_W-1:0] i_pow_a,
    input  logic signed [DATA_W-1:0] i_pow_b,
    input  logic signed [ACC_W-1:0]  i_acc,
    input  logic signed [PROD_W-1:0] i_term,
    input  logic signed [DATA_W-1:0] i_coeff,
    input  logic signed [DATA_W-1:0] i_quot,
    output t_ctl                     o_ctl,
    output logic signed [DATA_W-1:0] o_base_a,
    output logic signed [DATA_W-1:0] o_base_b,
    output logic signed [DATA_W-1:0] o_pow_a,
    output logic signed [DATA_W-1:0] o_pow_b,
    output logic signed [ACC_W-1:0]  o_acc,
    output logic signed [PROD_W-1:0] o_term
);

    // Only lanes that feed a later lane flag a clamp of the next power.
    localparam bit HAS_NEXT = (IDX < NUM_COEFFS - 1);

    t_ctl                         r1_ctl;
    logic signed [DATA_W-1:0]     r1_base_a;
    logic signed [DATA_W-1:0]     r1_base_b;
    logic signed [POW_PROD_W-1:0] r1_prod_a;
    logic signed [POW_PROD_W-1:0] r1_prod_b;
    logic signed [DIFF_W-1:0]     r1_diff;
    logic signed [ACC_W-1:0]      r1_acc;

    t_ctl                         r2_ctl;
    logic signed [DATA_W-1:0]     r2_base_a;
    logic signed [DATA_W-1:0]     r2_base_b;
    logic signed [DATA_W-1:0]     r2_pow_a;
    logic signed [DATA_W-1:0]     r2_pow_b;
    logic signed [ACC_W-1:0]      r2_acc;
    logic signed [PROD_W-1:0]     r2_term;

    logic signed [POW_PROD_W-1:0] prod_a;
    logic signed [POW_PROD_W-1:0] prod_b;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [ACC_W-1:0]      n_acc;
    logic signed [POW_PROD_W-1:0] sh_a;
    logic signed [POW_PROD_W-1:0] sh_b;
    t_sat                         sat_a;
    t_sat                         sat_b;
    logic signed [DATA_W-1:0]     k;
    logic signed [PROD_W-1:0]     term;
    logic                         pow_ovf;
    t_ctl                         n_ctl;

    // Stage 1: power products, limit difference, fold in the previous term.
    assign prod_a = i_pow_a * i_base_a;
    assign prod_b = i_pow_b * i_base_b;
    assign diff   = DIFF_W'(i_pow_b) - DIFF_W'(i_pow_a);
    assign n_acc  = i_acc + (ACC_W'(i_term) >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_base_a <= i_base_a;
            r1_base_b <= i_base_b;
            r1_prod_a <= prod_a;
            r1_prod_b <= prod_b;
            r1_diff   <= diff;
            r1_acc    <= n_acc;
        end
    end

    // Stage 2: truncate and clamp the next powers, form this lane's term.
    assign sh_a    = r1_prod_a >>> FRAC_BITS;
    assign sh_b    = r1_prod_b >>> FRAC_BITS;
    assign sat_a   = sat32(SAT_IN_W'(sh_a));
    assign sat_b   = sat32(SAT_IN_W'(sh_b));
    assign pow_ovf = HAS_NEXT && (sat_a.ovf || sat_b.ovf);

    // The integral uses the coefficient divided by its exponent plus one.
    assign k    = (IDX == 0 || r1_ctl.mode == MODE_EVAL) ? i_coeff : i_quot;
    assign term = r1_diff * k;

    // Control for the next stage picks up any power clamp.
    always_comb begin
        n_ctl     = r1_ctl;
        n_ctl.ovf = r1_ctl.ovf || pow_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_en) begin
            r2_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_base_a <= r1_base_a;
            r2_base_b <= r1_base_b;
            r2_pow_a  <= sat_a.val;
            r2_pow_b  <= sat_b.val;
            r2_acc    <= r1_acc;
            r2_term   <= term;
        end
    end

    assign o_ctl    = r2_ctl;
    assign o_base_a = r2_base_a;
    assign o_base_b = r2_base_b;
    assign o_pow_a  = r2_pow_a;
    assign o_pow_b  = r2_pow_b;
    assign o_acc    = r2_acc;
    assign o_term   = r2_term;

endmodule

@@ rtl/core/polynomial_eval_and_integral.sv @@
// An accepted request beat passes the entry stage, two register stages per lane and
// the final add and saturate stages before its result beat enters the result queue.
// Throughput: one request beat per cycle; a two-slot result queue lets requests flow
// while fewer than two results wait to be taken.
// Reset (synchronous, active low) empties the pipeline and queue and clears all
// coefficients; a write reaches the integral path through divider stages A, B and C.
module polynomial_eval_and_integral import pe_pkg::*; #(
    parameter int NUM_COEFFS = NUM_COEFFS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pe_in_if.sink   i_in,
    pe_out_if.source o_out,
    pe_cfg_if.sink  i_cfg
);

    localparam int ACC_W = PROD_W + $clog2(NUM_COEFFS) + 1;
    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

    logic                     cfg_wr;
    logic                     en;
    logic                     push;
    logic                     pop;

    logic signed [DATA_W-1:0] r_coeff [NUM_COEFFS];
    logic signed [DATA_W-1:0] quot    [NUM_COEFFS];

    t_ctl                     r_s0_ctl;
    t_ctl                     n_s0_ctl;
    logic signed [DATA_W-1:0] r_s0_base_a;
    logic signed [DATA_W-1:0] r_s0_base_b;
    logic signed [DATA_W-1:0] r_s0_pow_b;

    t_ctl                     ctl    [NUM_COEFFS+1];
    logic signed [DATA_W-1:0] base_a [NUM_COEFFS+1];
    logic signed [DATA_W-1:0] base_b [NUM_COEFFS+1];
    logic signed [DATA_W-1:0] pow_a  [NUM_COEFFS+1];
    logic signed [DATA_W-1:0] pow_b  [NUM_COEFFS+1];
    logic signed [ACC_W-1:0]  acc    [NUM_COEFFS+1];
    logic signed [PROD_W-1:0] term   [NUM_COEFFS+1];

    t_ctl                     r_f1_ctl;
    logic signed [ACC_W-1:0]  r_f1_acc;
    logic                     r_f2_v;
    logic signed [DATA_W-1:0] r_f2_val;
    logic                     r_f2_ovf;
    t_sat                     fsat;

    logic signed [DATA_W-1:0] r_q_val [2];
    logic                     r_q_ovf [2];
    logic                     r_wp;
    logic                     r_rp;
    logic [1:0]               r_cnt;

    // Coefficient registers; writes beyond the used coefficients are dropped.
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_COEFFS; j++) begin
                r_coeff[j] <= '0;
            end
        end else if (cfg_wr) begin
            for (int j = 0; j < NUM_COEFFS; j++) begin
                if (i_cfg.index == CFG_IDX_W'(j)) begin
                    r_coeff[j] <= i_cfg.data;
                end
            end
        end
    end

    pe_cdiv #(
        .NUM_COEFFS (NUM_COEFFS)
    ) u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_quot  (quot)
    );

    // The whole pipeline advances while the result queue has a free slot.
    assign en         = (r_cnt != 2'd2);
    assign i_in.ready = en;

    // Stage 0: pick the bases. Evaluation runs the b chain from 1.0 with
    // base x and keeps the a chain at zero.
    always_comb begin
        n_s0_ctl       = '0;
        n_s0_ctl.valid = i_in.valid;
        n_s0_ctl.mode  = t_mode'(i_in.mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
        end else if (en) begin
            r_s0_ctl <= n_s0_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (t_mode'(i_in.mode) == MODE_INTEG) begin
                r_s0_base_a <= i_in.lower_limit;
                r_s0_base_b <= i_in.upper_limit;
                r_s0_pow_b  <= i_in.upper_limit;
            end else begin
                r_s0_base_a <= '0;
                r_s0_base_b <= i_in.position;
                r_s0_pow_b  <= ONE;
            end
        end
    end

    assign ctl[0]    = r_s0_ctl;
    assign base_a[0] = r_s0_base_a;
    assign base_b[0] = r_s0_base_b;
    assign pow_a[0]  = r_s0_base_a;
    assign pow_b[0]  = r_s0_pow_b;
    assign acc[0]    = '0;
    assign term[0]   = '0;

    // One lane per coefficient.
    for (genvar g = 0; g < NUM_COEFFS; g++) begin : g_lane
        pe_lane #(
            .IDX        (g),
            .NUM_COEFFS (NUM_COEFFS),
            .FRAC_BITS  (FRAC_BITS),
            .ACC_W      (ACC_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_ctl    (ctl[g]),
            .i_base_a (base_a[g]),
            .i_base_b (base_b[g]),
            .i_pow_a  (pow_a[g]),
            .i_pow_b  (pow_b[g]),
            .i_acc    (acc[g]),
            .i_term   (term[g]),
            .i_coeff  (r_coeff[g]),
            .i_quot   (quot[g]),
            .o_ctl    (ctl[g+1]),
            .o_base_a (base_a[g+1]),
            .o_base_b (base_b[g+1]),
            .o_pow_a  (pow_a[g+1]),
            .o_pow_b  (pow_b[g+1]),
            .o_acc    (acc[g+1]),
            .o_term   (term[g+1])
        );
    end

    // Final add of the last term.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_ctl <= '0;
        end else if (en) begin
            r_f1_ctl <= ctl[NUM_COEFFS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_acc <= acc[NUM_COEFFS] + (ACC_W'(term[NUM_COEFFS]) >>> FRAC_BITS);
        end
    end

    // Saturate the sum to 32 bits.
    assign fsat = sat32(SAT_IN_W'(r_f1_acc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (en) begin
            r_f2_v <= r_f1_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_val <= fsat.val;
            r_f2_ovf <= r_f1_ctl.ovf || fsat.ovf;
        end
    end

    // Two-slot result queue.
    assign push = en && r_f2_v;
    assign pop  = (r_cnt != 2'd0) && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_val[r_wp] <= r_f2_val;
            r_q_ovf[r_wp] <= r_f2_ovf;
        end
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.result_value = r_q_val[r_rp];
    assign o_out.overflow     = r_q_ovf[r_rp];

    // The queue never holds more than two results.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result queue count out of range");

    // A stalled pipeline holds its last stage.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r_f2_v) |=> (r_f2_v && $stable(r_f2_val) && $stable(r_f2_ovf)))
        else $error("final stage changed during a stall");

    // Reset leaves the queue, the entry stage and the final stage empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cnt == 2'd0 && !r_s0_ctl.valid && !r_f2_v))
        else $error("pipeline not empty after reset");

endmodule
